[design/tgc_pkg.sv]
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types, constants and helpers for the touch gesture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

  localparam int COORD_BITS = 12;
  localparam int TIME_BITS  = 32;
  localparam int MAG_BITS   = (COORD_BITS > 12) ? COORD_BITS : 12;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [MAG_BITS-1:0]   mag_t;
  typedef logic [2:0]            gesture_t;

  // Gesture codes
  localparam gesture_t G_TAP     = 3'd0;
  localparam gesture_t G_DOUBLE  = 3'd1;
  localparam gesture_t G_RIGHT   = 3'd2;
  localparam gesture_t G_LEFT    = 3'd3;
  localparam gesture_t G_DOWN    = 3'd4;
  localparam gesture_t G_UP      = 3'd5;
  localparam gesture_t G_RELEASE = 3'd6;

  // Operations and report kinds
  localparam logic       OP_REPORT = 1'b0;
  localparam logic       OP_TICK   = 1'b1;
  localparam logic [1:0] KIND_X    = 2'd0;
  localparam logic [1:0] KIND_Y    = 2'd1;
  localparam logic [1:0] KIND_KEY  = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_RADIUS    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_RADIUS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_WINDOW = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_MAX       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONFIRM_DELAY = 3'd4;

  typedef struct packed {
    logic [11:0] tap_radius;
    logic [11:0] double_radius;
    logic [15:0] double_window_ms;
    logic [15:0] tap_max_ms;
    logic [15:0] confirm_delay_ms;
  } cfg_t;

  // Touch and tap history seen by the classifier at a release.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    time_t  now_ms;
    time_t  press_time;
    time_t  last_tap_time;
    coord_t last_tap_x;
    coord_t last_tap_y;
    logic   last_tap_valid;
  } cls_in_t;

  typedef struct packed {
    logic     is_tap;    // record this press as the last tap
    logic     arm;       // becomes the pending single tap, no result now
    gesture_t gesture;
  } cls_t;

  typedef struct packed {
    logic        valid;
    gesture_t    gesture;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
  } res_t;

  function automatic coord_t abs_diff(coord_t a, coord_t b);
    return (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  function automatic coord_t coord_in(logic [11:0] v);
    return coord_t'(v);
  endfunction

  function automatic logic [11:0] coord_out(coord_t v);
    return 12'(v);
  endfunction

endpackage

`default_nettype wire

[design/tgc_classify.sv]
// ----------------------------------------------------------------------------
// tgc_classify
// Release classifier: tap, double tap, four-way swipe or plain release.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_classify (
  input  wire tgc_pkg::cfg_t    cfg,
  input  wire tgc_pkg::cls_in_t st,
  output tgc_pkg::cls_t         cls
);

  tgc_pkg::coord_t ax, ay, ddx, ddy;
  tgc_pkg::mag_t   ax_m, ay_m, ddx_m, ddy_m, r_m, dr_m;
  tgc_pkg::time_t  since, held;
  logic            is_tap, is_double, big;

  always_comb begin
    ax    = tgc_pkg::abs_diff(st.end_x, st.start_x);
    ay    = tgc_pkg::abs_diff(st.end_y, st.start_y);
    ddx   = tgc_pkg::abs_diff(st.last_tap_x, st.start_x);
    ddy   = tgc_pkg::abs_diff(st.last_tap_y, st.start_y);
    ax_m  = tgc_pkg::mag_t'(ax);
    ay_m  = tgc_pkg::mag_t'(ay);
    ddx_m = tgc_pkg::mag_t'(ddx);
    ddy_m = tgc_pkg::mag_t'(ddy);
    r_m   = tgc_pkg::mag_t'(cfg.tap_radius);
    dr_m  = tgc_pkg::mag_t'(cfg.double_radius);
    since = tgc_pkg::time_t'(st.press_time - st.last_tap_time);
    held  = tgc_pkg::time_t'(st.now_ms - st.press_time);

    // A release without any end position counts as a tap.
    is_tap = ((st.end_x == '0) && (st.end_y == '0)) || ((ax_m < r_m) && (ay_m < r_m));
    is_double = st.last_tap_valid
             && (since < tgc_pkg::time_t'(cfg.double_window_ms))
             && (ddx_m < dr_m) && (ddy_m < dr_m);
    big = (ax_m > r_m) || (ay_m > r_m);

    cls.is_tap  = is_tap;
    cls.arm     = 1'b0;
    cls.gesture = tgc_pkg::G_RELEASE;
    if (is_tap) begin
      if (is_double) begin
        cls.gesture = tgc_pkg::G_DOUBLE;
      end else if (held < tgc_pkg::time_t'(cfg.tap_max_ms)) begin
        cls.arm = 1'b1;
      end
    end else if (big) begin
      if ((st.end_x > st.start_x) && (ax > ay)) begin
        cls.gesture = tgc_pkg::G_RIGHT;
      end else if ((st.end_x < st.start_x) && (ax > ay)) begin
        cls.gesture = tgc_pkg::G_LEFT;
      end else if ((st.end_y > st.start_y) && (ay > ax)) begin
        cls.gesture = tgc_pkg::G_DOWN;
      end else if ((st.end_y < st.start_y) && (ay > ax)) begin
        cls.gesture = tgc_pkg::G_UP;
      end
    end
  end

endmodule

`default_nettype wire

[design/tgc_engine.sv]
// ----------------------------------------------------------------------------
// tgc_engine
// Touch state, millisecond clock and pending tap; one item per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          operation,
  input  wire logic [1:0]    report_kind,
  input  wire logic [11:0]   report_value,
  input  wire tgc_pkg::cfg_t cfg,
  output tgc_pkg::res_t      res
);

  logic            pressed, pressed_next;
  tgc_pkg::coord_t start_x, start_x_next, start_y, start_y_next;
  tgc_pkg::coord_t end_x, end_x_next, end_y, end_y_next;
  tgc_pkg::time_t  now_ms, now_ms_next, press_time, press_time_next;
  tgc_pkg::time_t  last_tap_time, last_tap_time_next;
  tgc_pkg::coord_t last_tap_x, last_tap_x_next, last_tap_y, last_tap_y_next;
  logic            last_tap_valid, last_tap_valid_next;
  logic            tap_pending, tap_pending_next;
  tgc_pkg::time_t  pending_deadline, pending_deadline_next;
  tgc_pkg::coord_t pending_x, pending_x_next, pending_y, pending_y_next;

  tgc_pkg::cls_in_t cls_in;
  tgc_pkg::cls_t    cls;
  tgc_pkg::coord_t  val_c;
  logic [15:0]      delay;

  assign cls_in = '{
    start_x:        start_x,
    start_y:        start_y,
    end_x:          end_x,
    end_y:          end_y,
    now_ms:         now_ms,
    press_time:     press_time,
    last_tap_time:  last_tap_time,
    last_tap_x:     last_tap_x,
    last_tap_y:     last_tap_y,
    last_tap_valid: last_tap_valid
  };

  tgc_classify u_classify (
    .cfg (cfg),
    .st  (cls_in),
    .cls (cls)
  );

  always_comb begin
    val_c = tgc_pkg::coord_in(report_value);
    // A confirm delay of zero behaves as one tick.
    delay = (cfg.confirm_delay_ms != 16'd0) ? cfg.confirm_delay_ms : 16'd1;

    pressed_next          = pressed;
    start_x_next          = start_x;
    start_y_next          = start_y;
    end_x_next            = end_x;
    end_y_next            = end_y;
    now_ms_next           = now_ms;
    press_time_next       = press_time;
    last_tap_time_next    = last_tap_time;
    last_tap_x_next       = last_tap_x;
    last_tap_y_next       = last_tap_y;
    last_tap_valid_next   = last_tap_valid;
    tap_pending_next      = tap_pending;
    pending_deadline_next = pending_deadline;
    pending_x_next        = pending_x;
    pending_y_next        = pending_y;
    res                   = '0;

    if (operation == tgc_pkg::OP_TICK) begin
      now_ms_next = tgc_pkg::time_t'(now_ms + 1'b1);
      if (tap_pending && (now_ms_next == pending_deadline)) begin
        tap_pending_next = 1'b0;
        res.valid   = 1'b1;
        res.gesture = tgc_pkg::G_TAP;
        res.pos_x   = tgc_pkg::coord_out(pending_x);
        res.pos_y   = tgc_pkg::coord_out(pending_y);
      end
    end else begin
      case (report_kind)
        tgc_pkg::KIND_X: begin
          if (pressed) end_x_next = val_c;
          else         start_x_next = val_c;
        end
        tgc_pkg::KIND_Y: begin
          if (pressed) end_y_next = val_c;
          else         start_y_next = val_c;
        end
        tgc_pkg::KIND_KEY: begin
          if (!pressed && (report_value != 12'd0)) begin
            pressed_next    = 1'b1;
            press_time_next = now_ms;
            end_x_next      = '0;
            end_y_next      = '0;
          end else if (pressed && (report_value == 12'd0)) begin
            // Any release cancels an older pending tap.
            tap_pending_next = 1'b0;
            if (cls.is_tap) begin
              last_tap_time_next  = press_time;
              last_tap_x_next     = start_x;
              last_tap_y_next     = start_y;
              last_tap_valid_next = 1'b1;
            end
            if (cls.arm) begin
              tap_pending_next      = 1'b1;
              pending_deadline_next = tgc_pkg::time_t'(now_ms + tgc_pkg::time_t'(delay));
              pending_x_next        = start_x;
              pending_y_next        = start_y;
            end else begin
              res.valid   = 1'b1;
              res.gesture = cls.gesture;
              res.pos_x   = tgc_pkg::coord_out(start_x);
              res.pos_y   = tgc_pkg::coord_out(start_y);
            end
            pressed_next = 1'b0;
            start_x_next = '0;
            start_y_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed          <= 1'b0;
      start_x          <= '0;
      start_y          <= '0;
      end_x            <= '0;
      end_y            <= '0;
      now_ms           <= '0;
      press_time       <= '0;
      last_tap_time    <= '0;
      last_tap_x       <= '0;
      last_tap_y       <= '0;
      last_tap_valid   <= 1'b0;
      tap_pending      <= 1'b0;
      pending_deadline <= '0;
      pending_x        <= '0;
      pending_y        <= '0;
    end else if (step) begin
      pressed          <= pressed_next;
      start_x          <= start_x_next;
      start_y          <= start_y_next;
      end_x            <= end_x_next;
      end_y            <= end_y_next;
      now_ms           <= now_ms_next;
      press_time       <= press_time_next;
      last_tap_time    <= last_tap_time_next;
      last_tap_x       <= last_tap_x_next;
      last_tap_y       <= last_tap_y_next;
      last_tap_valid   <= last_tap_valid_next;
      tap_pending      <= tap_pending_next;
      pending_deadline <= pending_deadline_next;
      pending_x        <= pending_x_next;
      pending_y        <= pending_y_next;
    end
  end

endmodule

`default_nettype wire

[design/touch_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Tap, double tap and swipe recognizer over touch reports and ms ticks.
// ----------------------------------------------------------------------------
// Path: an item is held in the input register, then its result, if any, is
// loaded into the result register.
// Throughput: one item per cycle while the result register is free or emptying;
// the single pass through the classifier and state update sets this figure.
// Reset: synchronous; clears all touch state, the ms clock, the pending tap
// and loads the registers with their default values.
`default_nettype none

module touch_gesture_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               operation,
  input  wire logic [1:0]                         report_kind,
  input  wire logic [11:0]                        report_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [2:0]                              gesture,
  output logic [11:0]                             pos_x,
  output logic [11:0]                             pos_y,
  input  wire logic                               cfg_we,
  input  wire logic [tgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tgc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  tgc_pkg::cfg_t cfg;
  tgc_pkg::res_t res;

  logic        item_valid;
  logic        item_op;
  logic [1:0]  item_kind;
  logic [11:0] item_value;
  logic        advance;

  // The held item moves on whenever the result register is free or emptying.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_radius       <= 12'd20;
      cfg.double_radius    <= 12'd40;
      cfg.double_window_ms <= 16'd300;
      cfg.tap_max_ms       <= 16'd300;
      cfg.confirm_delay_ms <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        tgc_pkg::REG_TAP_RADIUS:    cfg.tap_radius       <= cfg_data[11:0];
        tgc_pkg::REG_DOUBLE_RADIUS: cfg.double_radius    <= cfg_data[11:0];
        tgc_pkg::REG_DOUBLE_WINDOW: cfg.double_window_ms <= cfg_data;
        tgc_pkg::REG_TAP_MAX:       cfg.tap_max_ms       <= cfg_data;
        tgc_pkg::REG_CONFIRM_DELAY: cfg.confirm_delay_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op    <= operation;
      item_kind  <= report_kind;
      item_value <= report_value;
    end
  end

  tgc_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .operation    (item_op),
    .report_kind  (item_kind),
    .report_value (item_value),
    .cfg          (cfg),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      gesture <= res.gesture;
      pos_x   <= res.pos_x;
      pos_y   <= res.pos_y;
    end
  end

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture <= tgc_pkg::G_RELEASE))
    else $error("gesture code out of range");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while held item cannot move");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("reset did not clear the pipeline");

  a_load_on_advance: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !item_valid) |=> !out_valid)
    else $error("result appeared without an item");

endmodule

`default_nettype wire
